/* rtl/core/rrc_pkg.sv */
`timescale 1ns / 1ps
package rrc_pkg;
    localparam int FifoDepthLog2 = 3;
    localparam int FifoDepth = 1 << FifoDepthLog2;

    localparam logic [3:0] K_TICK = 4'd0;
    localparam logic [3:0] K_CHAN = 4'd1;
    localparam logic [3:0] K_CHECK = 4'd2;
    localparam logic [3:0] K_CONN = 4'd3;
    localparam logic [3:0] K_DISC = 4'd4;
    localparam logic [3:0] K_READ = 4'd5;
    localparam logic [3:0] K_WRITE = 4'd6;
    localparam logic [3:0] K_RESP = 4'd7;
    localparam logic [3:0] K_CLEAR = 4'd8;
    localparam logic [3:0] K_START = 4'd9;
    localparam logic [3:0] K_STOP = 4'd10;
    localparam logic [3:0] K_LERR = 4'd11;
    localparam logic [3:0] K_RECOVER = 4'd12;

    localparam logic [2:0] OP_CHAN = 3'd0;
    localparam logic [2:0] OP_CHECK = 3'd1;
    localparam logic [2:0] OP_POLL = 3'd2;
    localparam logic [2:0] OP_CONN = 3'd3;
    localparam logic [2:0] OP_DISC = 3'd4;
    localparam logic [2:0] OP_READ = 3'd5;
    localparam logic [2:0] OP_WRITE = 3'd6;

    localparam logic [2:0] RT_CHECK = 3'd0;
    localparam logic [2:0] RT_POLL = 3'd1;
    localparam logic [2:0] RT_CONN = 3'd2;
    localparam logic [2:0] RT_DISC = 3'd3;
    localparam logic [2:0] RT_READ = 3'd4;
    localparam logic [2:0] RT_WRITE = 3'd5;

    localparam logic [3:0] EV_SEND = 4'd0;
    localparam logic [3:0] EV_CHAN = 4'd1;
    localparam logic [3:0] EV_TIMEOUT = 4'd2;
    localparam logic [3:0] EV_LINK = 4'd3;
    localparam logic [3:0] EV_READ = 4'd4;
    localparam logic [3:0] EV_CHECK = 4'd5;
    localparam logic [3:0] EV_FAIL = 4'd6;
    localparam logic [3:0] EV_IDLE = 4'd7;
    localparam logic [3:0] EV_ERROR = 4'd8;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_POLL = 3'd1;
    localparam logic [2:0] REG_SETTLE = 3'd2;
    localparam logic [2:0] REG_RETRY = 3'd3;
    localparam logic [2:0] REG_CRETRY = 3'd4;

    typedef enum logic [2:0] {
        MODE_READY = 3'b001,
        MODE_OPER  = 3'b010,
        MODE_ERROR = 3'b100
    } t_mode;

    typedef struct packed {
        logic [15:0] len;
        logic [7:0]  dref;
        logic [7:0]  chr;
        logic [7:0]  chan;
        logic [2:0]  op;
    } t_req;

    typedef struct packed {
        logic [15:0] unparsed;
        logic [15:0] length;
        logic [7:0]  data_ref;
        logic [7:0]  char_id;
        logic [7:0]  channel;
        logic [2:0]  pdu_type;
        logic [3:0]  ev;
    } t_res;

    // request kind to queued operation
    function automatic logic [2:0] kind_to_op(input logic [3:0] k);
        case (k)
            K_CHAN:  return OP_CHAN;
            K_CHECK: return OP_CHECK;
            K_CONN:  return OP_CONN;
            K_DISC:  return OP_DISC;
            K_READ:  return OP_READ;
            K_WRITE: return OP_WRITE;
            default: return OP_CHAN;
        endcase
    endfunction
endpackage

/* rtl/core/rrc_fifo.sv */
`timescale 1ns / 1ps
module rrc_fifo (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [rrc_pkg::FifoDepthLog2-1:0] i_waddr,
    input  rrc_pkg::t_req                   i_wdata,
    input  logic [rrc_pkg::FifoDepthLog2-1:0] i_raddr,
    output rrc_pkg::t_req                   o_rdata
);
    rrc_pkg::t_req r_mem [rrc_pkg::FifoDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/request_response_client.sv */
`timescale 1ns / 1ps
// channel      | dir | handshake            | contents
// config       | in  | i_cfg_we             | register index, write data
// s_axis       | in  | tvalid/tready        | one input transaction
// m_axis       | out | tvalid/tready, tlast | one result transaction
//
// an input transaction first reads the request fifo memory at its head and is
// then evaluated with the registered read data. results go into a two-entry
// output queue; a new input is taken while none is being evaluated and the
// queue is empty or its last result is being taken. reset is synchronous
// and clears all control state; fifo entries stay undefined until written.
module request_response_client (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[3:0], now_ms[35:4], channel[43:36], char_id[51:44],
    // data_ref[59:52], data_length[75:60], resp_type[78:76],
    // resp_ok[79], unparsed_size[95:80]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_event[3:0], out_pdu_type[6:4], out_channel[14:7],
    // out_char_id[22:15], out_data_ref[30:23], out_length[46:31],
    // out_unparsed[62:47], out_connected[63]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int AW = rrc_pkg::FifoDepthLog2;

    // configuration registers
    logic [15:0] r_timeout, r_poll_per, r_settle;
    logic [7:0]  r_max_ret, r_max_cret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd100;
            r_poll_per <= 16'd1000;
            r_settle <= 16'd50;
            r_max_ret <= 8'd3;
            r_max_cret <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rrc_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                rrc_pkg::REG_POLL:    r_poll_per <= i_cfg_data;
                rrc_pkg::REG_SETTLE:  r_settle <= i_cfg_data;
                rrc_pkg::REG_RETRY:   r_max_ret <= i_cfg_data[7:0];
                rrc_pkg::REG_CRETRY:  r_max_cret <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control state
    logic [AW:0]   r_count;
    logic [AW-1:0] r_head;
    rrc_pkg::t_mode r_mode;
    rrc_pkg::t_req r_cur;
    logic          r_link, r_await, r_settling;
    logic [7:0]    r_retry, r_act_chan;
    logic [31:0]   r_req_time, r_poll_time, r_settle_start;

    // stage 1 holds the accepted item while the fifo read completes
    logic          r_busy;
    logic [95:0]   r_in;

    // output queue
    rrc_pkg::t_res r_q0, r_q1;
    logic          r_q0v, r_q1v, r_q0last, r_q1last;
    logic          r_q0conn, r_q1conn;

    logic          q_free;
    assign q_free = !r_q0v || (!r_q1v && m_axis_tready);
    // tready drops for the evaluation cycle and while the queue has no room
    assign s_axis_tready = !r_busy && q_free;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    rrc_pkg::t_req fifo_rd, wr_req;
    logic          fifo_we;
    logic [AW-1:0] fifo_waddr;

    rrc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_we   (fifo_we),
        .i_waddr(fifo_waddr),
        .i_wdata(wr_req),
        .i_raddr(r_head),
        .o_rdata(fifo_rd)
    );

    // fields of the held item
    logic [3:0]  kind;
    logic [31:0] now;
    logic [7:0]  in_chan;
    logic [2:0]  rtype;
    logic        rok;
    logic [15:0] unp;
    assign kind = r_in[3:0];
    assign now = r_in[35:4];
    assign in_chan = r_in[43:36];
    assign rtype = r_in[78:76];
    assign rok = r_in[79];
    assign unp = r_in[95:80];

    assign wr_req.op = rrc_pkg::kind_to_op(kind);
    assign wr_req.chan = r_in[43:36];
    assign wr_req.chr = r_in[51:44];
    assign wr_req.dref = r_in[59:52];
    assign wr_req.len = r_in[75:60];
    assign fifo_waddr = r_head + r_count[AW-1:0];
    assign fifo_we = r_busy && kind >= rrc_pkg::K_CHAN && kind <= rrc_pkg::K_WRITE
                     && r_count < (AW+1)'(rrc_pkg::FifoDepth);

    // next-state evaluation
    logic [AW:0]   n_count;
    logic [AW-1:0] n_head;
    rrc_pkg::t_mode n_mode;
    rrc_pkg::t_req n_cur;
    logic          n_link, n_await, n_settling;
    logic [7:0]    n_retry, n_act_chan;
    logic [31:0]   n_req_time, n_poll_time, n_settle_start;
    rrc_pkg::t_res res [2];
    logic [1:0]    nres;

    logic [31:0] el_poll, el_settle, el_req;
    logic [8:0]  rn;
    logic [7:0]  lim;
    assign el_poll = now - r_poll_time;
    assign el_settle = now - r_settle_start;
    assign el_req = now - r_req_time;

    always_comb begin
        rrc_pkg::t_res e;
        logic do_start;
        logic [2:0] sop;
        n_count = r_count;
        n_head = r_head;
        n_mode = r_mode;
        n_cur = r_cur;
        n_link = r_link;
        n_await = r_await;
        n_settling = r_settling;
        n_retry = r_retry;
        n_act_chan = r_act_chan;
        n_req_time = r_req_time;
        n_poll_time = r_poll_time;
        n_settle_start = r_settle_start;
        res[0] = '0;
        res[1] = '0;
        nres = 2'd0;
        e = '0;
        do_start = 1'b0;
        sop = rrc_pkg::OP_CHAN;
        rn = {1'b0, r_retry} + 9'd1;
        lim = (r_cur.op == rrc_pkg::OP_CHECK) ? r_max_cret : r_max_ret;

        case (kind)
            rrc_pkg::K_TICK: begin
                if (r_mode == rrc_pkg::MODE_OPER) begin
                    // a poll sends one result and sets the wait, so nothing
                    // later in this tick can emit a second start
                    if (r_link && el_poll > {16'd0, r_poll_per} && !r_await) begin
                        n_cur.op = rrc_pkg::OP_POLL;
                        e.ev = rrc_pkg::EV_SEND;
                        e.pdu_type = 3'd1;
                        res[0] = e;
                        nres = 2'd1;
                        n_req_time = now;
                        n_await = 1'b1;
                        n_poll_time = now;
                    end
                    if (r_settling && el_settle > {16'd0, r_settle})
                        n_settling = 1'b0;
                    if (n_await) begin
                        if (el_req > {16'd0, r_timeout}) begin
                            if (!r_await) begin
                                // just polled: the poll has just set a fresh request time,
                                // so no retry or timeout is taken on the old one
                            end else begin
                                n_retry = rn[8] ? 8'hFF : rn[7:0];
                                if (rn <= {1'b0, lim}) begin
                                    do_start = 1'b1;
                                    sop = r_cur.op;
                                end else begin
                                    res[nres[0]] = '0;
                                    res[nres[0]].ev = rrc_pkg::EV_TIMEOUT;
                                    nres = nres + 2'd1;
                                    if (r_link) begin
                                        n_link = 1'b0;
                                        res[nres[0]] = '0;
                                        res[nres[0]].ev = rrc_pkg::EV_LINK;
                                        nres = nres + 2'd1;
                                    end
                                    n_await = 1'b0;
                                end
                            end
                        end
                    end else if (!n_settling) begin
                        if (r_count != '0) begin
                            n_cur = fifo_rd;
                            n_head = r_head + AW'(1);
                            n_count = r_count - (AW+1)'(1);
                            n_retry = 8'd0;
                            do_start = 1'b1;
                            sop = fifo_rd.op;
                        end else begin
                            res[0] = '0;
                            res[0].ev = rrc_pkg::EV_IDLE;
                            nres = 2'd1;
                        end
                    end
                    if (do_start) begin
                        e = '0;
                        e.ev = rrc_pkg::EV_SEND;
                        case (sop)
                            rrc_pkg::OP_CHAN: if (!n_link) begin
                                n_settling = 1'b1;
                                n_settle_start = now;
                                n_act_chan = n_cur.chan;
                                e.ev = rrc_pkg::EV_CHAN;
                                e.channel = n_cur.chan;
                                res[nres[0]] = e;
                                nres = nres + 2'd1;
                                n_await = 1'b0;
                            end
                            rrc_pkg::OP_CHECK, rrc_pkg::OP_CONN: if (!n_link) begin
                                e.pdu_type = (sop == rrc_pkg::OP_CHECK) ? 3'd0 : 3'd2;
                                res[nres[0]] = e;
                                nres = nres + 2'd1;
                                n_req_time = now;
                                n_await = 1'b1;
                            end
                            rrc_pkg::OP_POLL, rrc_pkg::OP_DISC, rrc_pkg::OP_READ,
                            rrc_pkg::OP_WRITE: if (n_link) begin
                                e.pdu_type = sop - 3'd1;
                                if (sop == rrc_pkg::OP_READ || sop == rrc_pkg::OP_WRITE)
                                    e.char_id = n_cur.chr;
                                if (sop == rrc_pkg::OP_WRITE) begin
                                    e.data_ref = n_cur.dref;
                                    e.length = n_cur.len;
                                end
                                if (sop == rrc_pkg::OP_POLL) n_poll_time = now;
                                res[nres[0]] = e;
                                nres = nres + 2'd1;
                                n_req_time = now;
                                n_await = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            rrc_pkg::K_RESP: begin
                if (r_mode == rrc_pkg::MODE_OPER && r_await) begin
                    case (rtype)
                        rrc_pkg::RT_CHECK: if (r_cur.op == rrc_pkg::OP_CHECK && !r_link) begin
                            res[0].ev = rrc_pkg::EV_CHECK;
                            res[0].channel = r_act_chan;
                            res[0].data_ref = r_cur.dref;
                            res[0].length = r_cur.len;
                            res[0].unparsed = unp;
                            nres = 2'd1;
                            n_await = 1'b0;
                        end
                        rrc_pkg::RT_POLL: if (r_cur.op == rrc_pkg::OP_POLL && r_link)
                            n_await = 1'b0;
                        rrc_pkg::RT_CONN: if (r_cur.op == rrc_pkg::OP_CONN && !r_link) begin
                            if (rok) begin
                                n_link = 1'b1;
                                n_poll_time = now;
                                res[0].ev = rrc_pkg::EV_LINK;
                            end else begin
                                res[0].ev = rrc_pkg::EV_FAIL;
                            end
                            nres = 2'd1;
                            n_await = 1'b0;
                        end
                        rrc_pkg::RT_DISC: if (r_cur.op == rrc_pkg::OP_DISC && r_link) begin
                            n_link = 1'b0;
                            res[0].ev = rrc_pkg::EV_LINK;
                            nres = 2'd1;
                            n_await = 1'b0;
                        end
                        rrc_pkg::RT_READ: if (r_cur.op == rrc_pkg::OP_READ && r_link) begin
                            if (rok) begin
                                res[0].ev = rrc_pkg::EV_READ;
                                res[0].char_id = r_cur.chr;
                                res[0].data_ref = r_cur.dref;
                                res[0].length = r_cur.len;
                                res[0].unparsed = unp;
                            end else begin
                                res[0].ev = rrc_pkg::EV_FAIL;
                            end
                            nres = 2'd1;
                            n_await = 1'b0;
                        end
                        rrc_pkg::RT_WRITE: if (r_cur.op == rrc_pkg::OP_WRITE && r_link) begin
                            if (!rok) begin
                                res[0].ev = rrc_pkg::EV_FAIL;
                                nres = 2'd1;
                            end
                            n_await = 1'b0;
                        end
                        default: n_await = 1'b0;
                    endcase
                end
            end
            rrc_pkg::K_CLEAR: begin
                n_count = '0;
                n_head = '0;
            end
            rrc_pkg::K_START: begin
                if (r_mode == rrc_pkg::MODE_READY) begin
                    n_count = '0;
                    n_head = '0;
                    n_await = 1'b0;
                    n_link = 1'b0;
                    n_settling = 1'b0;
                    n_act_chan = in_chan;
                    n_mode = rrc_pkg::MODE_OPER;
                end
            end
            rrc_pkg::K_STOP: if (r_mode == rrc_pkg::MODE_OPER) n_mode = rrc_pkg::MODE_READY;
            rrc_pkg::K_LERR: begin
                n_mode = rrc_pkg::MODE_ERROR;
                res[0].ev = rrc_pkg::EV_ERROR;
                nres = 2'd1;
            end
            rrc_pkg::K_RECOVER: n_mode = rrc_pkg::MODE_READY;
            default: begin
                // requests are queued by the fifo write path
                if (fifo_we) n_count = r_count + (AW+1)'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_count <= '0;
            r_head <= '0;
            r_mode <= rrc_pkg::MODE_READY;
            r_cur <= '0;
            r_link <= 1'b0;
            r_await <= 1'b0;
            r_settling <= 1'b0;
            r_retry <= '0;
            r_act_chan <= '0;
            r_req_time <= '0;
            r_poll_time <= '0;
            r_settle_start <= '0;
            r_q0v <= 1'b0;
            r_q1v <= 1'b0;
        end else begin
            r_busy <= s_acc;
            if (s_acc) r_in <= s_axis_tdata;
            // drain the queue
            if (m_axis_tvalid && m_axis_tready) begin
                r_q0 <= r_q1;
                r_q0v <= r_q1v;
                r_q0last <= r_q1last;
                r_q0conn <= r_q1conn;
                r_q1v <= 1'b0;
            end
            if (r_busy) begin
                r_count <= n_count;
                r_head <= n_head;
                r_mode <= n_mode;
                r_cur <= n_cur;
                r_link <= n_link;
                r_await <= n_await;
                r_settling <= n_settling;
                r_retry <= n_retry;
                r_act_chan <= n_act_chan;
                r_req_time <= n_req_time;
                r_poll_time <= n_poll_time;
                r_settle_start <= n_settle_start;
                // queue is empty here (or emptying), so results land in order
                if (nres != 2'd0) begin
                    r_q0 <= res[0];
                    r_q0v <= 1'b1;
                    r_q0last <= (nres == 2'd1);
                    r_q0conn <= n_link;
                    r_q1 <= res[1];
                    r_q1v <= (nres == 2'd2);
                    r_q1last <= 1'b1;
                    r_q1conn <= n_link;
                end
            end
        end
    end

    assign m_axis_tvalid = r_q0v;
    assign m_axis_tlast = r_q0last;
    assign m_axis_tdata = {r_q0conn, r_q0.unparsed, r_q0.length, r_q0.data_ref,
                           r_q0.char_id, r_q0.channel, r_q0.pdu_type, r_q0.ev};
endmodule
